/* src/lclb_pkg.sv */
package lclb_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int T_BITS = 16;
  localparam logic [T_BITS:0] T_ONE = (T_BITS+1)'(1) << T_BITS;

  localparam int CFG_W = 15;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] WIDTH_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  localparam int COORD_W = 32;
  localparam int BOUND_W = CFG_W + COORD_FRAC_BITS;
  localparam int P_W = COORD_W + 1;
  localparam int Q_W = ((BOUND_W > COORD_W) ? BOUND_W : COORD_W) + 1;
  localparam int PROD_W = T_BITS + 2 + P_W;
  localparam int NUM_W = T_BITS + 2 + COORD_W;
  localparam int DEN_W = NUM_W + 1;
  localparam int DW = ((Q_W > NUM_W) ? Q_W : NUM_W) - 2;
  localparam int RW = DW + 1;
  localparam int DIV_BPS = 2;
  localparam int DIV_STAGES = T_BITS / DIV_BPS;
  localparam logic signed [PROD_W-1:0] LERP_HALF = PROD_W'(T_ONE >> 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_depth;
    logic signed [COORD_W-1:0] first_w;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_depth;
    logic signed [COORD_W-1:0] second_w;
  } in_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [COORD_W-1:0] clip_first_x;
    logic signed [COORD_W-1:0] clip_first_y;
    logic signed [COORD_W-1:0] clip_first_depth;
    logic signed [COORD_W-1:0] clip_first_w;
    logic signed [COORD_W-1:0] clip_second_x;
    logic signed [COORD_W-1:0] clip_second_y;
    logic signed [COORD_W-1:0] clip_second_depth;
    logic signed [COORD_W-1:0] clip_second_w;
    logic [T_BITS:0]           persp_entry_param;
    logic [T_BITS:0]           persp_exit_param;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] n;
    logic [DW-1:0] d;
    logic          zero;
    logic          one;
  } div_in_t;

  function automatic logic [DW-1:0] mag(input logic signed [DEN_W-1:0] v);
    logic signed [DEN_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[DW-1:0];
  endfunction

endpackage

/* src/lclb_div.sv */
module lclb_div (
  input  logic                     clk,
  input  logic                     en,
  input  lclb_pkg::div_in_t        din,
  output logic [lclb_pkg::T_BITS:0] quo
);

  logic [lclb_pkg::RW-1:0]     rem_r  [0:lclb_pkg::DIV_STAGES];
  logic [lclb_pkg::DW-1:0]     d_r    [0:lclb_pkg::DIV_STAGES];
  logic [lclb_pkg::T_BITS-1:0] q_r    [0:lclb_pkg::DIV_STAGES];
  logic                        zero_r [0:lclb_pkg::DIV_STAGES];
  logic                        one_r  [0:lclb_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {1'b0, din.n};
      d_r[0]    <= din.d;
      q_r[0]    <= '0;
      zero_r[0] <= din.zero;
      one_r[0]  <= din.one;
    end
  end

  for (genvar k = 1; k <= lclb_pkg::DIV_STAGES; k++) begin : g_stage
    logic [lclb_pkg::RW-1:0]     rem_c;
    logic [lclb_pkg::T_BITS-1:0] q_c;

    always_comb begin
      rem_c = rem_r[k-1];
      q_c   = q_r[k-1];
      for (int i = 0; i < lclb_pkg::DIV_BPS; i++) begin
        rem_c = {rem_c[lclb_pkg::RW-2:0], 1'b0};
        if (rem_c >= {1'b0, d_r[k-1]}) begin
          rem_c = rem_c - {1'b0, d_r[k-1]};
          q_c   = {q_c[lclb_pkg::T_BITS-2:0], 1'b1};
        end else begin
          q_c   = {q_c[lclb_pkg::T_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_c;
        d_r[k]    <= d_r[k-1];
        q_r[k]    <= q_c;
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end
    end
  end

  assign quo = zero_r[lclb_pkg::DIV_STAGES] ? '0 :
               one_r[lclb_pkg::DIV_STAGES]  ? lclb_pkg::T_ONE :
               {1'b0, q_r[lclb_pkg::DIV_STAGES]};

endmodule

/* src/line_clip_liang_barsky.sv */
// Clips one line segment per request against the window [0, width] x [0, height].
// A request on in_data carries both endpoints; it is taken when in_valid and
// in_ready are high at a clock edge. Each request yields exactly one result on
// out_data, taken when out_valid and out_ready are high. A rejected segment
// returns accepted low and all other fields zero.
// The block is a 24-stage pipeline, and a new request is taken in every cycle
// in which the receiver does not stall. Most of the stages are the two banks
// of restoring dividers with 16-bit quotients, each an input register and
// eight stages of two quotient bits, for the edge parameters and for the
// perspective parameters.
// When the receiver stalls the whole pipeline holds and in_ready drops; nothing
// is lost or repeated. The window registers are written through cfg_we,
// cfg_idx and cfg_wdata and take effect for requests taken afterward; write
// them only while no request is in flight.
// Synchronous reset clears all valid bits and sets the window to 640 by 480.
module line_clip_liang_barsky (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lclb_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lclb_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [lclb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lclb_pkg::CFG_W-1:0]     cfg_wdata
);

  typedef struct packed {
    logic                                 rej;
    logic [3:0]                           ent;
    logic [3:0]                           ext;
    logic [3:0][lclb_pkg::COORD_W-1:0]    base;
    logic [3:0][lclb_pkg::P_W-1:0]        dif;
    logic [lclb_pkg::COORD_W-1:0]         w2;
  } side_t;

  logic en;
  logic [lclb_pkg::CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lclb_pkg::WIDTH_RST;
      height_r <= lclb_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lclb_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        lclb_pkg::REG_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Input register and edge terms.
  lclb_pkg::in_t in_r;
  logic v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
    end
  end

  logic signed [lclb_pkg::P_W-1:0] p_c [4];
  logic signed [lclb_pkg::Q_W-1:0] q_c [4];
  side_t side_c;

  always_comb begin
    p_c[0] = lclb_pkg::P_W'($signed(in_r.first_x)) - lclb_pkg::P_W'($signed(in_r.second_x));
    q_c[0] = lclb_pkg::Q_W'($signed(in_r.first_x));
    p_c[1] = -p_c[0];
    q_c[1] = lclb_pkg::Q_W'($signed({1'b0, width_r, {lclb_pkg::COORD_FRAC_BITS{1'b0}}}))
             - lclb_pkg::Q_W'($signed(in_r.first_x));
    p_c[2] = lclb_pkg::P_W'($signed(in_r.first_y)) - lclb_pkg::P_W'($signed(in_r.second_y));
    q_c[2] = lclb_pkg::Q_W'($signed(in_r.first_y));
    p_c[3] = -p_c[2];
    q_c[3] = lclb_pkg::Q_W'($signed({1'b0, height_r, {lclb_pkg::COORD_FRAC_BITS{1'b0}}}))
             - lclb_pkg::Q_W'($signed(in_r.first_y));
    side_c.base[0] = in_r.first_x;
    side_c.base[1] = in_r.first_y;
    side_c.base[2] = in_r.first_depth;
    side_c.base[3] = in_r.first_w;
    side_c.dif[0] = -p_c[0];
    side_c.dif[1] = -p_c[2];
    side_c.dif[2] = lclb_pkg::P_W'($signed(in_r.second_depth))
                    - lclb_pkg::P_W'($signed(in_r.first_depth));
    side_c.dif[3] = lclb_pkg::P_W'($signed(in_r.second_w))
                    - lclb_pkg::P_W'($signed(in_r.first_w));
    side_c.w2  = in_r.second_w;
    side_c.rej = 1'b0;
    for (int i = 0; i < 4; i++) begin
      side_c.ent[i] = p_c[i] < 0;
      side_c.ext[i] = p_c[i] > 0;
      if (p_c[i] == 0 && q_c[i] < 0) begin
        side_c.rej = 1'b1;
      end
    end
  end

  // Edge term register.
  logic signed [lclb_pkg::P_W-1:0] p_r [4];
  logic signed [lclb_pkg::Q_W-1:0] q_r [4];
  side_t side1_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_c;
      q_r     <= q_c;
      side1_r <= side_c;
    end
  end

  // Edge quotients.
  lclb_pkg::div_in_t edin_c [4];
  logic [lclb_pkg::T_BITS:0] qd [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      edin_c[i].n    = lclb_pkg::mag(lclb_pkg::DEN_W'(q_r[i]));
      edin_c[i].d    = lclb_pkg::mag(lclb_pkg::DEN_W'(p_r[i]));
      edin_c[i].zero = (q_r[i] == 0) || ((q_r[i] < 0) != (p_r[i] < 0));
      edin_c[i].one  = edin_c[i].n >= edin_c[i].d;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_edge_div
    lclb_div u_div (
      .clk (clk),
      .en  (en),
      .din (edin_c[i]),
      .quo (qd[i])
    );
  end

  side_t side_d_r [0:lclb_pkg::DIV_STAGES];
  logic [lclb_pkg::DIV_STAGES:0] vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[lclb_pkg::DIV_STAGES-1:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= side1_r;
      for (int k = 1; k <= lclb_pkg::DIV_STAGES; k++) begin
        side_d_r[k] <= side_d_r[k-1];
      end
    end
  end

  // Entry and exit parameters.
  logic [lclb_pkg::T_BITS:0] t0_c, t1_c;
  logic acc_c;
  side_t side_l;

  assign side_l = side_d_r[lclb_pkg::DIV_STAGES];

  always_comb begin
    t0_c = '0;
    t1_c = lclb_pkg::T_ONE;
    for (int i = 0; i < 4; i++) begin
      if (side_l.ent[i] && qd[i] > t0_c) begin
        t0_c = qd[i];
      end
      if (side_l.ext[i] && qd[i] < t1_c) begin
        t1_c = qd[i];
      end
    end
    acc_c = !side_l.rej && (t0_c < t1_c);
  end

  logic [lclb_pkg::T_BITS:0] t_r [2];
  logic acc2_r, v2_r;
  side_t side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= vd_r[lclb_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]  <= t0_c;
      t_r[1]  <= t1_c;
      acc2_r  <= acc_c;
      side2_r <= side_l;
    end
  end

  // Products for interpolation and perspective terms.
  logic signed [lclb_pkg::PROD_W-1:0] prod_r [2][4];
  logic signed [lclb_pkg::NUM_W-1:0]  num_r  [2];
  logic signed [lclb_pkg::NUM_W-1:0]  m_r    [2];
  logic [3:0][lclb_pkg::COORD_W-1:0]  base3_r;
  logic acc3_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 4; i++) begin
          prod_r[j][i] <= $signed({1'b0, t_r[j]}) * $signed(side2_r.dif[i]);
        end
        num_r[j] <= $signed({1'b0, t_r[j]}) * $signed(side2_r.w2);
        m_r[j]   <= $signed({1'b0, lclb_pkg::T_ONE - t_r[j]}) * $signed(side2_r.base[3]);
      end
      base3_r <= side2_r.base;
      acc3_r  <= acc2_r;
    end
  end

  // Interpolated endpoints and perspective denominators.
  logic signed [lclb_pkg::PROD_W-1:0] rnd_c [2][4];
  logic signed [lclb_pkg::PROD_W-1:0] sh_c  [2][4];
  logic [lclb_pkg::COORD_W-1:0]       lv_c  [2][4];
  logic signed [lclb_pkg::DEN_W-1:0]  den_c [2];
  lclb_pkg::out_t res_c;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 4; i++) begin
        rnd_c[j][i] = prod_r[j][i] + lclb_pkg::LERP_HALF;
        sh_c[j][i]  = rnd_c[j][i] >>> lclb_pkg::T_BITS;
        lv_c[j][i]  = base3_r[i] + sh_c[j][i][lclb_pkg::COORD_W-1:0];
      end
      den_c[j] = lclb_pkg::DEN_W'(m_r[j]) + lclb_pkg::DEN_W'(num_r[j]);
    end
    res_c                   = '0;
    res_c.accepted          = acc3_r;
    res_c.clip_first_x      = lv_c[0][0];
    res_c.clip_first_y      = lv_c[0][1];
    res_c.clip_first_depth  = lv_c[0][2];
    res_c.clip_first_w      = lv_c[0][3];
    res_c.clip_second_x     = lv_c[1][0];
    res_c.clip_second_y     = lv_c[1][1];
    res_c.clip_second_depth = lv_c[1][2];
    res_c.clip_second_w     = lv_c[1][3];
  end

  lclb_pkg::out_t res4_r;
  logic signed [lclb_pkg::NUM_W-1:0] num4_r [2];
  logic signed [lclb_pkg::DEN_W-1:0] den4_r [2];
  logic v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res4_r <= res_c;
      num4_r <= num_r;
      den4_r <= den_c;
    end
  end

  // Perspective quotients.
  lclb_pkg::div_in_t pdin_c [2];
  logic [lclb_pkg::T_BITS:0] qp [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pdin_c[j].n    = lclb_pkg::mag(lclb_pkg::DEN_W'(num4_r[j]));
      pdin_c[j].d    = lclb_pkg::mag(den4_r[j]);
      pdin_c[j].zero = (num4_r[j] == 0) || (den4_r[j] == 0)
                       || ((num4_r[j] < 0) != (den4_r[j] < 0));
      pdin_c[j].one  = pdin_c[j].n >= pdin_c[j].d;
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_persp_div
    lclb_div u_div (
      .clk (clk),
      .en  (en),
      .din (pdin_c[j]),
      .quo (qp[j])
    );
  end

  lclb_pkg::out_t res_d_r [0:lclb_pkg::DIV_STAGES];
  logic [lclb_pkg::DIV_STAGES:0] vp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (en) begin
      vp_r <= {vp_r[lclb_pkg::DIV_STAGES-1:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_d_r[0] <= res4_r;
      for (int k = 1; k <= lclb_pkg::DIV_STAGES; k++) begin
        res_d_r[k] <= res_d_r[k-1];
      end
    end
  end

  // Output register.
  lclb_pkg::out_t out_c;
  lclb_pkg::out_t out_r;
  logic out_valid_r;

  always_comb begin
    out_c                   = res_d_r[lclb_pkg::DIV_STAGES];
    out_c.persp_entry_param = qp[0];
    out_c.persp_exit_param  = qp[1];
    if (!res_d_r[lclb_pkg::DIV_STAGES].accepted) begin
      out_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vp_r[lclb_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
